// File: hw/rtl/attack_sharpness_meter_core_macros.svh
// ----------------------------------------------------------------------------
// Attack sharpness meter assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ATTACK_SHARPNESS_METER_CORE_MACROS_SVH
`define ATTACK_SHARPNESS_METER_CORE_MACROS_SVH

// same-cycle implication
`define ASM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/asm_pkg.sv
// ----------------------------------------------------------------------------
// Attack sharpness meter package
// Types, widths and constants shared by the meter core and its checker.
// ----------------------------------------------------------------------------
package asm_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int RATE_W  = 18;
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

    localparam int Q_FRAC  = 16;
    localparam int SHARP_W = 17;
    localparam int LEN_W   = 12;
    localparam int PEAK_W  = 16;

    localparam logic [SHARP_W-1:0] Q16_ONE = 17'h10000;

    localparam int OFS_SHARP  = 0;
    localparam int OFS_LEN    = OFS_SHARP + SHARP_W;
    localparam int OFS_PEAK   = OFS_LEN + LEN_W;
    localparam int OUT_USED_W = OFS_PEAK + PEAK_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

// File: hw/rtl/asm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module asm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/asm_div.sv
// ----------------------------------------------------------------------------
// Attack sharpness meter divider
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module asm_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: hw/rtl/attack_sharpness_meter_core.sv
// ----------------------------------------------------------------------------
// Attack sharpness meter core
// Stores a block of samples in RAM, tracks the peak, rescans for the ten
// percent crossing and converts the attack length to a Q1.16 sharpness.
//
//   port group   dir  tdata / tuser contents (low bit up)
//   s_axis       in   tdata: sample; tlast: end of block
//   m_axis       out  tdata: sharpness, attack_length, peak_magnitude; tuser: silent
//   i_cfg        in   wdata: conversion rate (Hz), written when i_cfg_we is high
//
// Load takes one sample per cycle; s_axis_tready stays high until tlast.
// After tlast: a RAM rescan from the first sample, which stops at the first
// crossing (at the latest at the peak), then the serial divider, then emit.
// An all-zero block skips rescan and divide.
// The next block loads while a result waits in the output register; a new
// result holds in emit, with s_axis_tready low, until that register is free.
// Reset is synchronous; the sample RAM needs no clearing.
// ----------------------------------------------------------------------------
module attack_sharpness_meter_core #(
    parameter int MAX_SAMPLES = asm_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = asm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // sample [SAMPLE_BITS-1:0], zero padded to bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tlast,
    output logic                                   s_axis_tready,
    // sharpness [16:0], attack_length [28:17], peak_magnitude [44:29]
    output logic [asm_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // silent [0]
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   i_cfg_we,
    input  logic [asm_pkg::RATE_W-1:0]             i_cfg_wdata
);

    import asm_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int MAG_W  = SAMPLE_BITS;
    localparam int NUM_W  = ADDR_W + 3 + Q_FRAC;

    t_state r_state, n_state;

    logic [CNT_W-1:0]       r_count;
    logic [MAG_W-1:0]       r_peak;
    logic [ADDR_W-1:0]      r_pos;
    logic [RATE_W-1:0]      r_rate;
    logic [ADDR_W-1:0]      r_rd_addr;
    logic                   r_chk_vld;
    logic [ADDR_W-1:0]      r_chk_addr;
    logic [ADDR_W-1:0]      r_len;
    logic                   r_silent;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic                   r_out_user;

    logic [SAMPLE_BITS-1:0] w_in_sample;
    logic [MAG_W-1:0]       w_in_mag;
    logic                   w_in_acc;
    logic                   w_we;
    logic                   w_new_peak;
    logic [MAG_W-1:0]       w_peak_final;
    logic                   w_last_acc;

    logic [SAMPLE_BITS-1:0] w_rd_sample;
    logic [MAG_W-1:0]       w_rd_mag;
    logic [MAG_W+3:0]       w_rd_mag10;
    logic                   w_hit;
    logic [ADDR_W-1:0]      w_len;
    logic [NUM_W-1:0]       w_num;
    logic [RATE_W-1:0]      w_den;

    logic                   w_div_start;
    logic                   w_div_done;
    logic [NUM_W-1:0]       w_quot;
    logic [SHARP_W-1:0]     w_t;
    logic [SHARP_W-1:0]     w_sharp;
    logic [OUT_DATA_W-1:0]  w_out_data;
    logic                   w_emit;

    // ---------------- input side ----------------
    always_comb begin
        w_in_sample  = s_axis_tdata[SAMPLE_BITS-1:0];
        w_in_mag     = w_in_sample[SAMPLE_BITS-1] ? (MAG_W'(~w_in_sample) + MAG_W'(1))
                                                  : MAG_W'(w_in_sample);
        w_in_acc     = s_axis_tvalid && s_axis_tready;
        w_we         = w_in_acc && (r_count < CNT_W'(MAX_SAMPLES));
        w_new_peak   = w_we && (w_in_mag > r_peak);
        w_peak_final = w_new_peak ? w_in_mag : r_peak;
        w_last_acc   = w_in_acc && s_axis_tlast;
    end

    asm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (w_in_sample),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rd_sample)
    );

    // ---------------- rescan side ----------------
    always_comb begin
        w_rd_mag   = w_rd_sample[SAMPLE_BITS-1] ? (MAG_W'(~w_rd_sample) + MAG_W'(1))
                                                : MAG_W'(w_rd_sample);
        w_rd_mag10 = {1'b0, w_rd_mag, 3'b000} + {3'b000, w_rd_mag, 1'b0};
        w_hit      = r_chk_vld && (w_rd_mag10 > (MAG_W+4)'(r_peak));
        w_len      = r_pos - r_chk_addr;
        w_num      = {({1'b0, w_len, 2'b00} + {3'b000, w_len}), {Q_FRAC{1'b0}}};
        w_den      = (r_rate == '0) ? RATE_W'(1) : r_rate;
    end

    asm_div #(
        .NUM_W (NUM_W),
        .DEN_W (RATE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_t     = (w_quot > NUM_W'(Q16_ONE)) ? Q16_ONE : SHARP_W'(w_quot);
        w_sharp = r_silent ? '0 : (Q16_ONE - w_t);
    end

    always_comb begin
        w_out_data                       = '0;
        w_out_data[OFS_SHARP +: SHARP_W] = w_sharp;
        w_out_data[OFS_LEN   +: LEN_W]   = LEN_W'(r_len);
        w_out_data[OFS_PEAK  +: PEAK_W]  = PEAK_W'(r_peak);
    end

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_last_acc) begin
                    n_state = (w_peak_final == '0) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_LOAD);
        w_div_start   = (r_state == ST_SCAN) && w_hit;
        w_emit        = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_peak      <= '0;
            r_pos       <= '0;
            r_rate      <= RATE_RESET;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end

            if (w_emit) begin
                r_count <= '0;
                r_peak  <= '0;
                r_pos   <= '0;
            end else if (w_we) begin
                r_count <= r_count + CNT_W'(1);
                if (w_new_peak) begin
                    r_peak <= w_in_mag;
                    r_pos  <= r_count[ADDR_W-1:0];
                end
            end

            r_chk_vld <= (r_state == ST_SCAN) && (n_state == ST_SCAN);

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            r_rd_addr <= r_rd_addr + ADDR_W'(1);
        end else begin
            r_rd_addr <= '0;
        end
        r_chk_addr <= r_rd_addr;

        if (w_last_acc) begin
            r_silent <= (w_peak_final == '0);
            r_len    <= '0;
        end else if (w_div_start) begin
            r_len <= w_len;
        end

        if (w_emit) begin
            r_out_data <= w_out_data;
            r_out_user <= r_silent;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// File: hw/rtl/asm_checker.sv
// ----------------------------------------------------------------------------
// Attack sharpness meter port checker
// Watches the result channel of the meter core; attached by bind.
// ----------------------------------------------------------------------------
`include "attack_sharpness_meter_core_macros.svh"

module asm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [asm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           m_axis_tuser
);

    import asm_pkg::*;

    `ASM_ASSERT_NEXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    `ASM_ASSERT_NEXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    `ASM_ASSERT_NOW(a_silent_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[OUT_USED_W-1:0] == '0, "silent result with nonzero fields")

    `ASM_ASSERT_NOW(a_zero_len_full, m_axis_tvalid && !m_axis_tuser && (m_axis_tdata[OFS_LEN +: LEN_W] == '0), m_axis_tdata[OFS_SHARP +: SHARP_W] == Q16_ONE, "zero attack length without full sharpness")

endmodule

bind attack_sharpness_meter_core asm_checker u_asm_checker (.*);

// File: verif/attack_sharpness_meter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Attack sharpness meter core testbench
// Streams blocks of signed samples into the core and checks every reading
// (sharpness, attack length, peak magnitude, silent flag) against a
// behavioral predictor of the ten-percent-to-peak attack measurement. Covers
// directed corner blocks, a sweep of sample rates, a long attack across a
// long block, long output back-pressure and a random run of shaped attacks,
// noise, silence and ties, with random idling on both streams.
// ----------------------------------------------------------------------------
module attack_sharpness_meter_core_test;
    import asm_pkg::*;

    localparam int STORE_DEPTH = MAX_SAMPLES_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 480;
    localparam int LONG_BLOCK = 400;

    typedef struct packed {
        logic [SHARP_W-1:0] sharp;
        logic [LEN_W-1:0]   attack_len;
        logic [PEAK_W-1:0]  peak;
        logic               silent;
    } meter_reading_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic [15:0]           s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tlast;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  i_cfg_we;
    logic [RATE_W-1:0]     i_cfg_wdata;

    // predictor state
    logic [15:0]       blk_store [STORE_DEPTH];
    int unsigned       blk_count;
    int unsigned       blk_peak;
    int unsigned       blk_pos;
    logic [RATE_W-1:0] cur_rate;

    meter_reading_t expected_readings[$];
    int  mismatches;
    int  readings_checked;
    int  samples_sent;
    int  blocks_sent;
    int  cycles;
    int  rx_hold_cycles;
    bit  idle_on;

    attack_sharpness_meter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d readings outstanding", cycles,
                 expected_readings.size());
        $display("** attack_sharpness_meter_core: FAILED **");
        $finish;
    end

    function automatic int unsigned level_of(logic [15:0] raw);
        return raw[15] ? (32'd65536 - raw) : {16'd0, raw};
    endfunction

    function automatic logic [15:0] signed_level(int unsigned lvl, bit neg);
        logic [15:0] v;
        v = lvl[15:0];
        return neg ? (~v + 16'd1) : v;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic predict_attack(logic [15:0] raw, bit lst);
        int unsigned    lvl;
        int unsigned    start;
        int unsigned    len_v;
        longint unsigned rate_v;
        longint unsigned t;
        meter_reading_t r;
        if (blk_count < STORE_DEPTH) begin
            lvl = level_of(raw);
            blk_store[blk_count] = raw;
            if (lvl > blk_peak) begin
                blk_peak = lvl;
                blk_pos = blk_count;
            end
            blk_count++;
        end
        if (lst) begin
            r = '0;
            if (blk_peak == 0) begin
                r.silent = 1'b1;
            end else begin
                start = blk_pos;
                for (int i = 0; i < blk_pos; i++) begin
                    if (10 * level_of(blk_store[i]) > blk_peak) begin
                        start = i;
                        break;
                    end
                end
                len_v = blk_pos - start;
                rate_v = (cur_rate == 0) ? 1 : cur_rate;
                t = (longint'(len_v) * 5 * 65536) / rate_v;
                if (t > 65536) t = 65536;
                r.sharp = SHARP_W'(65536 - t);
                r.attack_len = len_v[LEN_W-1:0];
                r.peak = blk_peak[PEAK_W-1:0];
            end
            expected_readings.push_back(r);
            blk_count = 0;
            blk_peak = 0;
            blk_pos = 0;
            blocks_sent++;
        end
    endtask

    task automatic push_sample(logic [15:0] smp, bit lst);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        s_axis_tlast <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
        predict_attack(smp, lst);
    endtask

    task automatic send_block(logic [15:0] smp[$]);
        foreach (smp[i]) push_sample(smp[i], i == smp.size() - 1);
    endtask

    task automatic wait_readings_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [RATE_W-1:0] rate);
        wait_readings_drained();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= rate;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_rate = rate;
    endtask

    // Silence, spike, noise, flat, or quiet lead-in, ramp to random peak, ragged decay.
    task automatic send_random_block(int n);
        logic [15:0] smp[$];
        int unsigned pk_lvl;
        int unsigned lvl;
        int pk_at;
        int rise_at;
        int kind;
        kind = $urandom_range(0, 19);
        pk_at = $urandom_range(0, n - 1);
        rise_at = $urandom_range(0, pk_at);
        pk_lvl = $urandom_range(1, 32768);
        for (int i = 0; i < n; i++) begin
            if (kind == 0) begin
                lvl = 0;
            end else if (kind == 1) begin
                lvl = (i == pk_at) ? pk_lvl : 0;
            end else if (kind < 4) begin
                smp.push_back(16'($urandom));
                continue;
            end else if (kind < 6) begin
                lvl = pk_lvl;
            end else if (i < rise_at) begin
                lvl = $urandom_range(0, pk_lvl / 8);
            end else if (i <= pk_at) begin
                lvl = pk_lvl * (i - rise_at + 1) / (pk_at - rise_at + 1);
            end else begin
                lvl = $urandom_range(0, pk_lvl);
            end
            smp.push_back(signed_level(lvl, $urandom_range(0, 1)));
        end
        send_block(smp);
    endtask

    function automatic int random_block_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) return $urandom_range(1, 24);
        if (pick < 97) return $urandom_range(25, 120);
        return $urandom_range(200, 500);
    endfunction

    always @(posedge i_clk) begin : check_readings
        meter_reading_t want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            readings_checked++;
            if (expected_readings.size() == 0) begin
                flag_mismatch("unexpected reading, sharpness",
                              m_axis_tdata[OFS_SHARP +: SHARP_W], -1);
            end else begin
                want = expected_readings.pop_front();
                if (m_axis_tdata[OFS_SHARP +: SHARP_W] !== want.sharp)
                    flag_mismatch("sharpness", m_axis_tdata[OFS_SHARP +: SHARP_W],
                                  want.sharp);
                if (m_axis_tdata[OFS_LEN +: LEN_W] !== want.attack_len)
                    flag_mismatch("attack_length", m_axis_tdata[OFS_LEN +: LEN_W],
                                  want.attack_len);
                if (m_axis_tdata[OFS_PEAK +: PEAK_W] !== want.peak)
                    flag_mismatch("peak_magnitude", m_axis_tdata[OFS_PEAK +: PEAK_W],
                                  want.peak);
                if (m_axis_tuser !== want.silent)
                    flag_mismatch("silent", m_axis_tuser, want.silent);
            end
        end
    end

    initial begin : drive_result_ready
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(1, 13) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        push_sample(16'h0000, 1);
        push_sample(16'h8000, 1);
        push_sample(16'd100, 0);
        push_sample(16'd5000, 0);
        push_sample(16'h8000, 1);
        // equal to a tenth of the peak does not cross
        push_sample(16'd1000, 0);
        push_sample(16'd1001, 0);
        push_sample(16'd10000, 1);
        push_sample(16'd1, 0);
        push_sample(16'd2, 0);
        push_sample(16'd30000, 1);
        // first of two equal magnitudes is the peak
        push_sample(16'd5000, 0);
        push_sample(16'd20000, 0);
        push_sample(16'hB1E0, 0);
        push_sample(16'd3, 1);
        repeat (3) push_sample(16'h0000, 0);
        push_sample(16'h0000, 1);
        push_sample(16'hFFFF, 0);
        push_sample(16'h7FFF, 1);
        push_sample(16'h7FFF, 0);
        push_sample(16'h0001, 1);
        wait_readings_drained();
    endtask

    task automatic test_rate_sweep();
        logic [RATE_W-1:0] rates[6];
        rates = '{18'd0, 18'd1, 18'd8000, 18'd192000, 18'h3FFFF, RATE_RESET};
        foreach (rates[k]) begin
            write_rate(rates[k]);
            repeat (4) send_random_block($urandom_range(2, 40));
        end
        wait_readings_drained();
    endtask

    task automatic test_long_blocks();
        // longest attack in the block: crossing at the first sample, peak at the last
        for (int i = 0; i < LONG_BLOCK; i++)
            push_sample(i == 0 ? 16'd4000 : (i == LONG_BLOCK - 1 ? 16'h7FFF : 16'h0000),
                        i == LONG_BLOCK - 1);
        write_rate(18'd8000);
        send_random_block(300);
        wait_readings_drained();
    endtask

    task automatic test_output_stall();
        write_rate(18'd44100);
        rx_hold_cycles = 600;
        repeat (4) send_random_block($urandom_range(3, 12));
        // pause the input until every reading is out, then resume
        wait_readings_drained();
        repeat (3) send_random_block($urandom_range(3, 12));
        wait_readings_drained();
    endtask

    task automatic test_random_blocks();
        int start_items;
        int next_cfg;
        int pick;
        start_items = samples_sent;
        next_cfg = 160;
        while (samples_sent - start_items < RANDOM_ITEMS) begin
            if (samples_sent - start_items >= next_cfg) begin
                next_cfg += 160;
                pick = $urandom_range(0, 9);
                if (pick == 0) write_rate(18'd8000);
                else if (pick == 1) write_rate(18'd192000);
                else if (pick == 2) write_rate(18'd0);
                else write_rate(RATE_W'($urandom_range(8000, 192000)));
            end
            idle_on = ($urandom_range(0, 3) != 0);
            send_random_block(random_block_len());
        end
        wait_readings_drained();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        write_rate(RATE_RESET);
        repeat (12) send_random_block($urandom_range(1, 24));
        wait_readings_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        blk_count = 0;
        blk_peak = 0;
        blk_pos = 0;
        cur_rate = RATE_RESET;
        mismatches = 0;
        readings_checked = 0;
        samples_sent = 0;
        blocks_sent = 0;
        rx_hold_cycles = 0;
        idle_on = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_rate_sweep();
        test_long_blocks();
        test_output_stall();
        test_random_blocks();
        test_back_to_back();

        repeat (50) @(posedge i_clk);
        $display("covered %0d samples in %0d blocks, %0d readings checked",
                 samples_sent, blocks_sent, readings_checked);
        $display("rates from 0 to full scale, long attacks, output stalls");
        if (mismatches == 0) begin
            $display("** attack_sharpness_meter_core: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** attack_sharpness_meter_core: FAILED **");
        end
        $finish;
    end

endmodule
